// ----- design/mep_pkg.sv -----
// ----------------------------------------------------------------------------
// mep_pkg
// shared types, constants and the control program of the escape pixel unit
// ----------------------------------------------------------------------------
package mep_pkg;

	// fixed field widths
	localparam int PIX_BITS      = 12;
	localparam int DIM_REG_BITS  = 13;
	localparam int COUNT_BITS    = 8;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 5;
	localparam int IN_DATA_BITS  = 24;
	localparam int OUT_DATA_BITS = 16;

	// parameter defaults
	localparam int DEF_COORD_BITS = 32;
	localparam int DEF_MAX_DIM    = 4096;

	localparam logic [COUNT_BITS-1:0] SHADE_MAX = 8'd255;

	// register reset values
	localparam logic [CFG_DATA_BITS-1:0] RST_LEFT_REAL   = 32'hE000_0000;
	localparam logic [CFG_DATA_BITS-1:0] RST_TOP_IMAG    = 32'h1000_0000;
	localparam logic [CFG_DATA_BITS-1:0] RST_RIGHT_REAL  = 32'h1000_0000;
	localparam logic [CFG_DATA_BITS-1:0] RST_BOTTOM_IMAG = 32'hF000_0000;
	localparam logic [DIM_REG_BITS-1:0]  RST_WIDTH       = 13'd640;
	localparam logic [DIM_REG_BITS-1:0]  RST_HEIGHT      = 13'd480;
	localparam logic [COUNT_BITS-1:0]    RST_LIMIT       = 8'd255;
	localparam logic [COUNT_BITS-1:0]    RST_NO_ESCAPE   = 8'd255;

	typedef enum logic [2:0] {
		REG_LEFT_REAL   = 3'd0,
		REG_TOP_IMAG    = 3'd1,
		REG_RIGHT_REAL  = 3'd2,
		REG_BOTTOM_IMAG = 3'd3,
		REG_WIDTH       = 3'd4,
		REG_HEIGHT      = 3'd5,
		REG_LIMIT       = 3'd6,
		REG_NO_ESCAPE   = 3'd7
	} reg_idx_t;

	// sequencer
	typedef logic [3:0] pc_t;

	localparam pc_t ST_IDLE  = 4'd0;
	localparam pc_t ST_PROD  = 4'd1;
	localparam pc_t ST_DIVX  = 4'd2;
	localparam pc_t ST_WAITX = 4'd3;
	localparam pc_t ST_CR    = 4'd4;
	localparam pc_t ST_WAITY = 4'd5;
	localparam pc_t ST_CI    = 4'd6;
	localparam pc_t ST_MUL   = 4'd7;
	localparam pc_t ST_UPD   = 4'd8;
	localparam pc_t ST_OUT   = 4'd9;

	typedef enum logic [2:0] {
		C_NEXT     = 3'd0,
		C_GOTO     = 3'd1,
		C_WAIT_IN  = 3'd2,
		C_WAIT_DIV = 3'd3,
		C_LOOP     = 3'd4,
		C_WAIT_OUT = 3'd5
	} cond_t;

	typedef struct packed {
		logic  latch_in;
		logic  calc_prod;
		logic  div_start;
		logic  div_y;
		logic  load_cr;
		logic  load_ci;
		logic  calc_mul;
		logic  calc_upd;
		logic  out_load;
		cond_t cond;
		pc_t   target;
	} ctl_word_t;

	typedef struct packed {
		logic div_busy;
		logic loop_exit;
	} dp_status_t;

	function automatic ctl_word_t ucode_rom(input pc_t pc);
		ctl_word_t w;
		w = '0;
		w.cond = C_NEXT;
		w.target = ST_IDLE;
		case (pc)
			ST_IDLE: begin
				w.latch_in = 1'b1;
				w.cond = C_WAIT_IN;
			end
			ST_PROD: begin
				w.calc_prod = 1'b1;
			end
			ST_DIVX: begin
				w.div_start = 1'b1;
			end
			ST_WAITX: begin
				w.cond = C_WAIT_DIV;
			end
			ST_CR: begin
				w.load_cr = 1'b1;
				w.div_start = 1'b1;
				w.div_y = 1'b1;
			end
			ST_WAITY: begin
				w.cond = C_WAIT_DIV;
			end
			ST_CI: begin
				w.load_ci = 1'b1;
			end
			ST_MUL: begin
				w.calc_mul = 1'b1;
			end
			ST_UPD: begin
				w.calc_upd = 1'b1;
				w.cond = C_LOOP;
				w.target = ST_MUL;
			end
			ST_OUT: begin
				w.out_load = 1'b1;
				w.cond = C_WAIT_OUT;
				w.target = ST_IDLE;
			end
			default: begin
				w.cond = C_GOTO;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- design/mep_div.sv -----
// ----------------------------------------------------------------------------
// mep_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mep_div #(
	parameter int NUM_BITS = 45,
	parameter int DEN_BITS = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                busy,
	output logic [NUM_BITS-1:0] quotient
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] dsr_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   trial;
	logic                fits;

	assign trial = {rem_q, quo_q[NUM_BITS-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_BITS'(NUM_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_BITS'(trial - {1'b0, dsr_q}) : DEN_BITS'(trial);
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- design/mep_seq.sv -----
// ----------------------------------------------------------------------------
// mep_seq
// step counter and control store of the pixel program
// ----------------------------------------------------------------------------
module mep_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_free,
	input  mep_pkg::dp_status_t status,
	output mep_pkg::ctl_word_t  ctl,
	output mep_pkg::pc_t        pc
);
	import mep_pkg::*;

	pc_t       pc_q;
	pc_t       pc_inc;
	pc_t       pc_nxt;
	ctl_word_t word;

	assign word   = ucode_rom(pc_q);
	assign pc_inc = pc_t'(pc_q + 1'b1);

	always_comb begin
		case (word.cond)
			C_NEXT:     pc_nxt = pc_inc;
			C_GOTO:     pc_nxt = word.target;
			C_WAIT_IN:  pc_nxt = in_valid ? pc_inc : pc_q;
			C_WAIT_DIV: pc_nxt = status.div_busy ? pc_q : pc_inc;
			C_LOOP:     pc_nxt = status.loop_exit ? pc_inc : word.target;
			C_WAIT_OUT: pc_nxt = out_free ? word.target : pc_q;
			default:    pc_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	assign ctl = word;
	assign pc  = pc_q;

endmodule

// ----- design/mep_datapath.sv -----
// ----------------------------------------------------------------------------
// mep_datapath
// coordinate mapping and z*z + c iteration under control of the sequencer
// ----------------------------------------------------------------------------
module mep_datapath #(
	parameter int COORD_BITS = mep_pkg::DEF_COORD_BITS,
	parameter int DIM_BITS   = 13
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mep_pkg::ctl_word_t                 ctl,
	input  logic                               in_accept,
	input  logic [mep_pkg::PIX_BITS-1:0]       pixel_x,
	input  logic [mep_pkg::PIX_BITS-1:0]       pixel_y,
	input  logic signed [COORD_BITS-1:0]       left_real,
	input  logic signed [COORD_BITS-1:0]       top_imag,
	input  logic signed [COORD_BITS-1:0]       right_real,
	input  logic signed [COORD_BITS-1:0]       bottom_imag,
	input  logic [DIM_BITS-1:0]                width_eff,
	input  logic [DIM_BITS-1:0]                height_eff,
	input  logic [mep_pkg::COUNT_BITS-1:0]     iteration_limit,
	input  logic [mep_pkg::COUNT_BITS-1:0]     no_escape_value,
	output mep_pkg::dp_status_t                status,
	output logic [mep_pkg::COUNT_BITS-1:0]     escape_count
);
	import mep_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int FRAC = C - 4;
	localparam int PW   = PIX_BITS + C + 1;
	localparam int SW   = 2 * C + 2;
	localparam int MW   = 2 * C + 1;
	localparam logic [MW-1:0] FOUR_WIDE = MW'(1) << (2 * FRAC + 2);

	function automatic logic signed [C-1:0] sat_coord(input logic signed [SW-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones = &v[SW-1:C-1];
		hi_zeros = ~|v[SW-1:C-1];
		if (hi_ones || hi_zeros) begin
			return v[C-1:0];
		end else if (v[SW-1]) begin
			return {1'b1, {(C-1){1'b0}}};
		end else begin
			return {1'b0, {(C-1){1'b1}}};
		end
	endfunction

	logic [PIX_BITS-1:0]   px_q;
	logic [PIX_BITS-1:0]   py_q;
	logic signed [PW-1:0]  prod_x_q;
	logic signed [PW-1:0]  prod_y_q;
	logic signed [C-1:0]   cr_q;
	logic signed [C-1:0]   ci_q;
	logic signed [C-1:0]   zr_q;
	logic signed [C-1:0]   zi_q;
	logic signed [2*C-1:0] rr_q;
	logic signed [2*C-1:0] ii_q;
	logic signed [2*C-1:0] ri_q;
	logic [COUNT_BITS-1:0] iter_q;
	logic [COUNT_BITS-1:0] count_q;

	logic signed [PW-1:0]  dx;
	logic signed [PW-1:0]  dy;
	logic signed [PW-1:0]  px_s;
	logic signed [PW-1:0]  py_s;
	logic signed [PW-1:0]  prod_sel;
	logic [PW-1:0]         div_num;
	logic [PW-1:0]         div_q;
	logic                  div_busy;
	logic signed [PW:0]    q_pos;
	logic signed [SW-1:0]  cr_sum;
	logic signed [SW-1:0]  ci_sum;
	logic signed [SW-1:0]  re_diff;
	logic signed [SW-1:0]  nr_sum;
	logic signed [SW-1:0]  ni_sum;
	logic [MW-1:0]         mag;
	logic                  escaped;
	logic                  at_limit;

	// coordinate spans and pixel offsets
	assign dx   = PW'(right_real) - PW'(left_real);
	assign dy   = PW'(top_imag) - PW'(bottom_imag);
	assign px_s = $signed(PW'(px_q));
	assign py_s = $signed(PW'(py_q));

	assign prod_sel = ctl.div_y ? prod_y_q : prod_x_q;
	assign div_num  = prod_sel[PW-1] ? PW'(-prod_sel) : PW'(prod_sel);

	mep_div #(
		.NUM_BITS(PW),
		.DEN_BITS(DIM_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_num),
		.divisor  (ctl.div_y ? height_eff : width_eff),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// truncating quotient: sign follows the product
	assign q_pos  = $signed({1'b0, div_q});
	assign cr_sum = SW'(left_real) + (prod_x_q[PW-1] ? -SW'(q_pos) : SW'(q_pos));
	assign ci_sum = SW'(top_imag) + (prod_y_q[PW-1] ? SW'(q_pos) : -SW'(q_pos));

	// z update and escape test
	assign re_diff = SW'(rr_q) - SW'(ii_q);
	assign nr_sum  = (re_diff >>> FRAC) + SW'(cr_q);
	assign ni_sum  = (SW'(ri_q) >>> (FRAC - 1)) + SW'(ci_q);
	assign mag     = MW'($unsigned(rr_q)) + MW'($unsigned(ii_q));

	assign escaped  = (iter_q != '0) && (mag >= FOUR_WIDE);
	assign at_limit = iter_q == iteration_limit;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (ctl.calc_prod) begin
			prod_x_q <= px_s * dx;
			prod_y_q <= py_s * dy;
		end
		if (ctl.load_cr) begin
			cr_q <= sat_coord(cr_sum);
		end
		if (ctl.load_ci) begin
			ci_q <= sat_coord(ci_sum);
			zr_q <= '0;
			zi_q <= '0;
			iter_q <= '0;
		end
		if (ctl.calc_mul) begin
			rr_q <= (2*C)'(zr_q) * (2*C)'(zr_q);
			ii_q <= (2*C)'(zi_q) * (2*C)'(zi_q);
			ri_q <= (2*C)'(zr_q) * (2*C)'(zi_q);
		end
		if (ctl.calc_upd) begin
			zr_q <= sat_coord(nr_sum);
			zi_q <= sat_coord(ni_sum);
			iter_q <= iter_q + 1'b1;
			if (escaped) begin
				count_q <= iter_q - 1'b1;
			end else if (at_limit) begin
				count_q <= no_escape_value;
			end
		end
	end

	assign status.div_busy  = div_busy;
	assign status.loop_exit = escaped || at_limit;
	assign escape_count     = count_q;

endmodule

// ----- design/mandelbrot_escape_pixel_unit.sv -----
// one item at a time: the next item is taken once the result sits in the output register
// the time per pixel is set by the bit-serial coordinate divider and the two-step loop of
// three multipliers
// reset: asynchronous, clears the sequencer, output valid and registers to defaults
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit
// escape-time count and shade for one pixel of a configurable complex window
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_unit #(
	parameter int COORD_BITS = mep_pkg::DEF_COORD_BITS,
	parameter int MAX_DIM    = mep_pkg::DEF_MAX_DIM
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// apb configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mep_pkg::CFG_ADDR_BITS-1:0]    paddr,
	input  logic [mep_pkg::CFG_DATA_BITS-1:0]    pwdata,
	output logic [mep_pkg::CFG_DATA_BITS-1:0]    prdata,
	output logic                                 pready,
	// pixel in
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mep_pkg::IN_DATA_BITS-1:0]     s_tdata,  // pixel_x, pixel_y
	// result out
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mep_pkg::OUT_DATA_BITS-1:0]    m_tdata   // escape_count, shade
);
	import mep_pkg::*;

	localparam int DIM_BITS = $clog2(MAX_DIM + 1);

	logic [CFG_DATA_BITS-1:0] left_q;
	logic [CFG_DATA_BITS-1:0] top_q;
	logic [CFG_DATA_BITS-1:0] right_q;
	logic [CFG_DATA_BITS-1:0] bottom_q;
	logic [DIM_REG_BITS-1:0]  width_q;
	logic [DIM_REG_BITS-1:0]  height_q;
	logic [COUNT_BITS-1:0]    limit_q;
	logic [COUNT_BITS-1:0]    no_escape_q;

	logic                     cfg_wr;
	reg_idx_t                 cfg_idx;
	logic [DIM_BITS-1:0]      width_eff;
	logic [DIM_BITS-1:0]      height_eff;

	ctl_word_t                ctl;
	pc_t                      pc;
	dp_status_t               dp_st;
	logic                     in_accept;
	logic                     out_free;
	logic                     out_valid_q;
	logic [COUNT_BITS-1:0]    count;
	logic [COUNT_BITS-1:0]    out_count_q;
	logic [COUNT_BITS-1:0]    out_shade_q;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= RST_LEFT_REAL;
			top_q <= RST_TOP_IMAG;
			right_q <= RST_RIGHT_REAL;
			bottom_q <= RST_BOTTOM_IMAG;
			width_q <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			limit_q <= RST_LIMIT;
			no_escape_q <= RST_NO_ESCAPE;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LEFT_REAL:   left_q <= pwdata;
				REG_TOP_IMAG:    top_q <= pwdata;
				REG_RIGHT_REAL:  right_q <= pwdata;
				REG_BOTTOM_IMAG: bottom_q <= pwdata;
				REG_WIDTH:       width_q <= pwdata[DIM_REG_BITS-1:0];
				REG_HEIGHT:      height_q <= pwdata[DIM_REG_BITS-1:0];
				REG_LIMIT:       limit_q <= pwdata[COUNT_BITS-1:0];
				REG_NO_ESCAPE:   no_escape_q <= pwdata[COUNT_BITS-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_LEFT_REAL:   prdata = left_q;
			REG_TOP_IMAG:    prdata = top_q;
			REG_RIGHT_REAL:  prdata = right_q;
			REG_BOTTOM_IMAG: prdata = bottom_q;
			REG_WIDTH:       prdata = CFG_DATA_BITS'(width_q);
			REG_HEIGHT:      prdata = CFG_DATA_BITS'(height_q);
			REG_LIMIT:       prdata = CFG_DATA_BITS'(limit_q);
			REG_NO_ESCAPE:   prdata = CFG_DATA_BITS'(no_escape_q);
			default:         prdata = '0;
		endcase
	end

	// image sizes: zero counts as one, clipped to the largest size
	always_comb begin
		if (width_q == '0) begin
			width_eff = DIM_BITS'(1);
		end else if (32'(width_q) > 32'(MAX_DIM)) begin
			width_eff = DIM_BITS'(MAX_DIM);
		end else begin
			width_eff = DIM_BITS'(width_q);
		end
		if (height_q == '0) begin
			height_eff = DIM_BITS'(1);
		end else if (32'(height_q) > 32'(MAX_DIM)) begin
			height_eff = DIM_BITS'(MAX_DIM);
		end else begin
			height_eff = DIM_BITS'(height_q);
		end
	end

	// control and datapath
	assign s_tready  = ctl.latch_in;
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	mep_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.status   (dp_st),
		.ctl      (ctl),
		.pc       (pc)
	);

	mep_datapath #(
		.COORD_BITS (COORD_BITS),
		.DIM_BITS   (DIM_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.in_accept       (in_accept),
		.pixel_x         (s_tdata[PIX_BITS-1:0]),
		.pixel_y         (s_tdata[2*PIX_BITS-1:PIX_BITS]),
		.left_real       ($signed(COORD_BITS'(left_q))),
		.top_imag        ($signed(COORD_BITS'(top_q))),
		.right_real      ($signed(COORD_BITS'(right_q))),
		.bottom_imag     ($signed(COORD_BITS'(bottom_q))),
		.width_eff       (width_eff),
		.height_eff      (height_eff),
		.iteration_limit (limit_q),
		.no_escape_value (no_escape_q),
		.status          (dp_st),
		.escape_count    (count)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load && out_free) begin
			out_count_q <= count;
			out_shade_q <= SHADE_MAX - count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_shade_q, out_count_q};

	// checks
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !dp_st.div_busy)
		else $error("divider busy while waiting for an item");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready)
		else $error("second item taken before the first finished");

	a_shade: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:8] == SHADE_MAX - m_tdata[7:0]))
		else $error("shade does not match count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[7:0] < limit_q) || (m_tdata[7:0] == no_escape_q)))
		else $error("escape count beyond iteration limit");

	a_load_at_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_load && out_free) |-> (pc == ST_OUT))
		else $error("result loaded outside the output step");

endmodule

// ----- sim/tb_mandelbrot_escape_pixel_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_pixel_unit
// self-checking bench: pixels go in on the input stream and each escape count
// and shade is compared with a behavioral escape-time calculation kept in
// step with the window registers written over apb
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_pixel_unit;
	import mep_pkg::*;

	localparam int COORD_W = DEF_COORD_BITS;
	localparam int FRAC_W = COORD_W - 4;
	localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam longint COORD_LO = -COORD_HI - 64'sd1;
	localparam longint unsigned ESCAPE_MAG = 64'd4 << (2 * FRAC_W);
	localparam int CLK_HALF = 4;
	localparam int DRAIN_CYCLES = 700;
	localparam int HOLD_OFF_CYCLES = 2500;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel_y;
		logic [PIX_BITS-1:0] pixel_x;
	} pixel_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] shade;
		logic [COUNT_BITS-1:0] escape_count;
	} escape_t;

	typedef struct {
		pixel_t  pix;
		escape_t res;
	} pending_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;

	// window registers as the bench believes them to be
	logic signed [CFG_DATA_BITS-1:0] win_left;
	logic signed [CFG_DATA_BITS-1:0] win_top;
	logic signed [CFG_DATA_BITS-1:0] win_right;
	logic signed [CFG_DATA_BITS-1:0] win_bottom;
	logic [DIM_REG_BITS-1:0]         img_w;
	logic [DIM_REG_BITS-1:0]         img_h;
	logic [COUNT_BITS-1:0]           iter_limit;
	logic [COUNT_BITS-1:0]           no_escape;

	pending_t pending_escapes[$];
	pending_t got_front;
	escape_t  got_res;

	bit idling_on;
	int hold_asked;
	int hold_granted;
	int hold_left;
	int stall_left;
	int idle_cycles;
	int mismatches;
	int pixels_sent;
	int results_seen;
	int escaped_early;
	int windows_set;

	mandelbrot_escape_pixel_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // pixel_x, pixel_y
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // escape_count, shade
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_HI) return COORD_HI;
		if (v < COORD_LO) return COORD_LO;
		return v;
	endfunction

	function automatic int clamp_dim(input logic [DIM_REG_BITS-1:0] d);
		if (d == '0) return 1;
		if (int'(d) > DEF_MAX_DIM) return DEF_MAX_DIM;
		return int'(d);
	endfunction

	function automatic escape_t predict_escape(input pixel_t p, output bit escaped);
		longint px, py, cr, ci, zr, zi, nr, ni;
		longint unsigned mag;
		logic [COUNT_BITS-1:0] count;
		escape_t r;
		px = longint'(p.pixel_x);
		py = longint'(p.pixel_y);
		cr = clamp_coord(longint'(win_left)
			+ (px * (longint'(win_right) - longint'(win_left))) / longint'(clamp_dim(img_w)));
		ci = clamp_coord(longint'(win_top)
			- (py * (longint'(win_top) - longint'(win_bottom))) / longint'(clamp_dim(img_h)));
		zr = 0;
		zi = 0;
		count = no_escape;
		escaped = 1'b0;
		for (int i = 0; i < int'(iter_limit); i++) begin
			nr = clamp_coord(((zr * zr - zi * zi) >>> FRAC_W) + cr);
			ni = clamp_coord(((64'sd2 * zr * zi) >>> FRAC_W) + ci);
			zr = nr;
			zi = ni;
			mag = zr * zr + zi * zi;
			if (mag >= ESCAPE_MAG) begin
				count = i[COUNT_BITS-1:0];
				escaped = 1'b1;
				break;
			end
		end
		r.escape_count = count;
		r.shade = SHADE_MAX - count;
		return r;
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] shadow_value(input reg_idx_t idx);
		case (idx)
			REG_LEFT_REAL:   return win_left;
			REG_TOP_IMAG:    return win_top;
			REG_RIGHT_REAL:  return win_right;
			REG_BOTTOM_IMAG: return win_bottom;
			REG_WIDTH:       return {{(CFG_DATA_BITS-DIM_REG_BITS){1'b0}}, img_w};
			REG_HEIGHT:      return {{(CFG_DATA_BITS-DIM_REG_BITS){1'b0}}, img_h};
			REG_LIMIT:       return {{(CFG_DATA_BITS-COUNT_BITS){1'b0}}, iter_limit};
			REG_NO_ESCAPE:   return {{(CFG_DATA_BITS-COUNT_BITS){1'b0}}, no_escape};
			default:         return '0;
		endcase
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want, got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %0h, got %0h", what, want, got);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			results_seen++;
			got_res = m_tdata;
			if (pending_escapes.size() == 0) begin
				note_mismatch("result with no pixel pending", '0, 32'(m_tdata));
			end else begin
				got_front = pending_escapes.pop_front();
				if (got_res.escape_count !== got_front.res.escape_count)
					note_mismatch($sformatf("escape_count of pixel (%0d,%0d)",
						got_front.pix.pixel_x, got_front.pix.pixel_y),
						32'(got_front.res.escape_count), 32'(got_res.escape_count));
				if (got_res.shade !== got_front.res.shade)
					note_mismatch($sformatf("shade of pixel (%0d,%0d)",
						got_front.pix.pixel_x, got_front.pix.pixel_y),
						32'(got_front.res.shade), 32'(got_res.shade));
			end
		end
	end

	// result receiver: random stall bursts plus requested long hold-offs
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_granted != hold_asked) begin
				hold_granted = hold_asked;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1)
			|| (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles with no transfer", idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic apb_access(input logic wr, input reg_idx_t idx,
		input logic [CFG_DATA_BITS-1:0] wdata, output logic [CFG_DATA_BITS-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic verify_registers();
		logic [CFG_DATA_BITS-1:0] rd;
		reg_idx_t idx;
		for (int r = 0; r <= int'(REG_NO_ESCAPE); r++) begin
			idx = reg_idx_t'(r);
			apb_access(1'b0, idx, '0, rd);
			if (rd !== shadow_value(idx))
				note_mismatch($sformatf("readback of %s", idx.name()), shadow_value(idx), rd);
		end
	endtask

	task automatic set_window(input logic [31:0] lr, ti, rr, bi,
		input logic [DIM_REG_BITS-1:0] w, h, input logic [COUNT_BITS-1:0] lim, ne);
		logic [CFG_DATA_BITS-1:0] rd;
		reg_idx_t idx;
		win_left = lr;
		win_top = ti;
		win_right = rr;
		win_bottom = bi;
		img_w = w;
		img_h = h;
		iter_limit = lim;
		no_escape = ne;
		for (int r = 0; r <= int'(REG_NO_ESCAPE); r++) begin
			idx = reg_idx_t'(r);
			apb_access(1'b1, idx, shadow_value(idx), rd);
		end
		verify_registers();
		windows_set++;
	endtask

	task automatic sender_rest(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_BITS-1:0] x, y);
		pixel_t pix;
		pending_t want;
		bit escaped;
		pix.pixel_x = x;
		pix.pixel_y = y;
		want.pix = pix;
		want.res = predict_escape(pix, escaped);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_escapes.push_back(want);
		pixels_sent++;
		if (escaped) escaped_early++;
		if (idling_on && $urandom_range(0, 5) == 0) sender_rest($urandom_range(1, 9));
	endtask

	task automatic wait_drained();
		sender_rest(1);
		while (pending_escapes.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_values();
		win_left = RST_LEFT_REAL;
		win_top = RST_TOP_IMAG;
		win_right = RST_RIGHT_REAL;
		win_bottom = RST_BOTTOM_IMAG;
		img_w = RST_WIDTH;
		img_h = RST_HEIGHT;
		iter_limit = RST_LIMIT;
		no_escape = RST_NO_ESCAPE;
		verify_registers();
		// corner escapes at once, center of the cardioid never escapes
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd320, 12'd240);
		send_pixel(12'd639, 12'd479);
		// far outside the image, both parts of c saturate
		send_pixel(12'd4095, 12'd4095);
		wait_drained();
	endtask

	task automatic test_extreme_corners();
		// widest window, zero sizes used as one
		set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			13'd0, 13'd0, 8'd3, 8'h5A);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd4095);
		wait_drained();
		// oversized width clamps to the largest image
		set_window(32'hE000_0000, 32'h1800_0000, 32'h1000_0000, 32'hE800_0000,
			13'd8191, 13'd4096, 8'd200, 8'hC3);
		send_pixel(12'd2730, 12'd2048);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd1024, 12'd3000);
		wait_drained();
	endtask

	task automatic test_iteration_limits();
		set_window(RST_LEFT_REAL, RST_TOP_IMAG, RST_RIGHT_REAL, RST_BOTTOM_IMAG,
			RST_WIDTH, RST_HEIGHT, 8'd0, 8'h81);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd320, 12'd240);
		wait_drained();
		set_window(RST_LEFT_REAL, RST_TOP_IMAG, RST_RIGHT_REAL, RST_BOTTOM_IMAG,
			RST_WIDTH, RST_HEIGHT, 8'd1, 8'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd320, 12'd240);
		send_pixel(12'd100, 12'd100);
		wait_drained();
		set_window(RST_LEFT_REAL, RST_TOP_IMAG, RST_RIGHT_REAL, RST_BOTTOM_IMAG,
			RST_WIDTH, RST_HEIGHT, 8'd255, 8'd0);
		send_pixel(12'd320, 12'd240);
		send_pixel(12'd420, 12'd140);
		wait_drained();
	endtask

	task automatic test_stall_and_drain();
		set_window(RST_LEFT_REAL, RST_TOP_IMAG, RST_RIGHT_REAL, RST_BOTTOM_IMAG,
			13'd64, 13'd48, 8'd20, 8'd7);
		// receiver holds off while pixels keep coming, so the input backs up
		hold_asked++;
		repeat (8) send_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 47)));
		wait_drained();
		// sender resumes only after everything came back
		repeat (6) send_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 47)));
		wait_drained();
	endtask

	task automatic test_random_windows();
		longint lft, spn, tp;
		logic [31:0] lr, ti, rr, bi, swap;
		logic [DIM_REG_BITS-1:0] w, h;
		logic [COUNT_BITS-1:0] lim, ne;
		int wx, hy, n;
		for (int phase = 0; phase < 8; phase++) begin
			idling_on = (phase < 7);
			if ($urandom_range(0, 5) == 0) begin
				lr = $urandom;
				ti = $urandom;
				rr = $urandom;
				bi = $urandom;
			end else begin
				lft = longint'($urandom_range(0, 32'h3000_0000)) - 64'sh2000_0000;
				spn = longint'($urandom_range(32'h0000_1000, 32'h3000_0000));
				lr = 32'(lft);
				rr = 32'(lft + spn);
				tp = longint'($urandom_range(0, 32'h1800_0000));
				spn = longint'($urandom_range(32'h0000_1000, 32'h3000_0000));
				ti = 32'(tp);
				bi = 32'(tp - spn);
				if ($urandom_range(0, 7) == 0) begin
					swap = lr;
					lr = rr;
					rr = swap;
				end
			end
			w = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
				: 13'($urandom_range(1, 48));
			h = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
				: 13'($urandom_range(1, 48));
			lim = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 48));
			ne = 8'($urandom_range(0, 255));
			set_window(lr, ti, rr, bi, w, h, lim, ne);
			wx = clamp_dim(w);
			hy = clamp_dim(h);
			n = (phase == 7) ? 100 : 55;
			repeat (n) begin
				if ($urandom_range(0, 3) == 0)
					send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
				else
					send_pixel(12'($urandom_range(0, wx - 1)), 12'($urandom_range(0, hy - 1)));
			end
			wait_drained();
		end
	endtask

	task automatic finish_run();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d pixels over %0d window settings, with stall bursts and a long hold-off",
			pixels_sent, windows_set);
		$display("%0d pixels escaped before the limit, %0d results checked, %0d mismatches",
			escaped_early, results_seen, mismatches);
		if (mismatches == 0 && pending_escapes.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		idling_on = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_extreme_corners();
		test_iteration_limits();
		test_stall_and_drain();
		test_random_windows();
		finish_run();
	end

endmodule

// ----- mandelbrot_escape_pixel_unit.f -----
design/mep_pkg.sv
design/mep_div.sv
design/mep_seq.sv
design/mep_datapath.sv
design/mandelbrot_escape_pixel_unit.sv
sim/tb_mandelbrot_escape_pixel_unit.sv
